/* sv/glyph_coverage_pixel_blend_top_macros.svh */
// ----------------------------------------------------------------------------
// Glyph coverage pixel blend assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef GLYPH_COVERAGE_PIXEL_BLEND_TOP_MACROS_SVH
`define GLYPH_COVERAGE_PIXEL_BLEND_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GCPB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent ends.
`define GCPB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/gcpb_pkg.sv */
// ----------------------------------------------------------------------------
// Glyph coverage pixel blend package
// Widths, register indexes, reset values and the pixel pack, unpack and mix
// functions.
// ----------------------------------------------------------------------------
package gcpb_pkg;

    localparam int unsigned PIXEL_W     = 16;
    localparam int unsigned COLOR_W     = 24;
    localparam int unsigned CH_W        = 8;
    localparam int unsigned COV_W       = 8;
    localparam int unsigned DOWN_W      = 3;
    localparam int unsigned UP_W        = 4;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 24;

    typedef logic [PIXEL_W-1:0]     pixel_t;
    typedef logic [CH_W-1:0]        chan_t;
    typedef logic [COV_W-1:0]       cov_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    // Register indexes on the configuration port.
    localparam cfg_index_t REG_TEXT_COLOR  = 3'd0;
    localparam cfg_index_t REG_BLEND_MODE  = 3'd1;
    localparam cfg_index_t REG_RED_DOWN    = 3'd2;
    localparam cfg_index_t REG_RED_UP      = 3'd3;
    localparam cfg_index_t REG_GREEN_DOWN  = 3'd4;
    localparam cfg_index_t REG_GREEN_UP    = 3'd5;
    localparam cfg_index_t REG_BLUE_DOWN   = 3'd6;

    // Blend mode codes.
    localparam logic MODE_SOLID = 1'b0;
    localparam logic MODE_BLEND = 1'b1;

    // Special coverage codes.
    localparam cov_t COV_NONE = 8'h00;
    localparam cov_t COV_FULL = 8'hFF;

    // Pixel format: per-channel shifts.
    typedef struct packed {
        logic [DOWN_W-1:0] red_down;
        logic [UP_W-1:0]   red_up;
        logic [DOWN_W-1:0] green_down;
        logic [UP_W-1:0]   green_up;
        logic [DOWN_W-1:0] blue_down;
    } fmt_t;

    localparam logic [COLOR_W-1:0] RST_TEXT_COLOR = 24'hFFFFFF;
    localparam logic               RST_BLEND_MODE = MODE_SOLID;
    localparam fmt_t RST_FMT = '{
        red_down:   3'd3,
        red_up:     4'd11,
        green_down: 3'd2,
        green_up:   4'd5,
        blue_down:  3'd3
    };

    // Drop the low bits of each channel, move it to its field and merge.
    function automatic pixel_t pack_px(chan_t r, chan_t g, chan_t b, fmt_t f);
        pixel_t rr;
        pixel_t gg;
        pixel_t bb;
        rr = PIXEL_W'(r >> f.red_down);
        gg = PIXEL_W'(g >> f.green_down);
        bb = PIXEL_W'(b >> f.blue_down);
        return (rr << f.red_up) | (gg << f.green_up) | bb;
    endfunction

    // Pull a field out of a pixel and scale it back up to eight bits.
    function automatic chan_t unpack_ch(pixel_t px, logic [UP_W-1:0] up,
                                        logic [DOWN_W-1:0] down);
        chan_t fld;
        fld = CH_W'(px >> up);
        return fld << down;
    endfunction

    // dst*(255-c)/256 + col*c/256, truncated to eight bits.
    function automatic chan_t mix_ch(chan_t d, chan_t col, cov_t c);
        cov_t                  inv;
        logic [2*CH_W-1:0]     pd;
        logic [2*CH_W-1:0]     pc;
        inv = COV_FULL - c;
        pd  = d * inv;
        pc  = col * c;
        return pd[2*CH_W-1:CH_W] + pc[2*CH_W-1:CH_W];
    endfunction

endpackage

/* sv/glyph_coverage_pixel_blend_top.sv */
// ----------------------------------------------------------------------------
// Glyph coverage pixel blend
// Text compositor for a 16-bit packed frame buffer, one pixel per clock unless stalled.
// ----------------------------------------------------------------------------
// Each request carries one glyph coverage byte and the current destination
// pixel, and produces exactly one result: the pixel to store and a write
// enable. The block takes one request per clock when the output side is not
// stalled, and its result passes through an input register and a result
// register. The request sits in the input register while the packing of the
// text color, the unpacking of the destination and the six 8x8 multiplies of
// the blend (two per channel) settle; the result register then holds the
// answer until it is taken. That multiply-and-add path between the two
// registers sets the clock rate. A stalled result does not block intake at
// once: the input register still accepts one more request while the result
// register waits, and only then does the block stop taking requests.
// Configuration writes are taken in every cycle and must only be issued
// while no request is in flight.
// ----------------------------------------------------------------------------
module glyph_coverage_pixel_blend_top (
    input  logic                             clk,
    input  logic                             rst_n,

    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gcpb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gcpb_pkg::CFG_DATA_W-1:0]  cfg_data,

    // Pixel requests.
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [gcpb_pkg::COV_W-1:0]       coverage,
    input  logic [gcpb_pkg::PIXEL_W-1:0]     dest_pixel,

    // Results.
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [gcpb_pkg::PIXEL_W-1:0]     new_pixel,
    output logic                             write_enable
);

    // Configuration registers.
    logic [gcpb_pkg::COLOR_W-1:0] text_color_reg;
    logic                         blend_mode_reg;
    gcpb_pkg::fmt_t               fmt_reg;

    // Input stage.
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    gcpb_pkg::cov_t               cov_reg;
    gcpb_pkg::pixel_t             dest_reg;

    // Result stage.
    logic                         out_valid_reg;
    logic                         out_valid_next;
    gcpb_pkg::pixel_t             new_pixel_reg;
    gcpb_pkg::pixel_t             new_pixel_next;
    logic                         write_enable_reg;
    logic                         write_enable_next;

    logic                         in_accept;
    logic                         s1_advance;

    gcpb_pkg::chan_t              col_r;
    gcpb_pkg::chan_t              col_g;
    gcpb_pkg::chan_t              col_b;
    gcpb_pkg::pixel_t             packed_color;
    gcpb_pkg::chan_t              dst_r;
    gcpb_pkg::chan_t              dst_g;
    gcpb_pkg::chan_t              dst_b;
    gcpb_pkg::pixel_t             blended;

    // The configuration port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= gcpb_pkg::RST_TEXT_COLOR;
            blend_mode_reg <= gcpb_pkg::RST_BLEND_MODE;
            fmt_reg        <= gcpb_pkg::RST_FMT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gcpb_pkg::REG_TEXT_COLOR: text_color_reg     <= cfg_data;
                gcpb_pkg::REG_BLEND_MODE: blend_mode_reg     <= cfg_data[0];
                gcpb_pkg::REG_RED_DOWN:   fmt_reg.red_down   <= cfg_data[2:0];
                gcpb_pkg::REG_RED_UP:     fmt_reg.red_up     <= cfg_data[3:0];
                gcpb_pkg::REG_GREEN_DOWN: fmt_reg.green_down <= cfg_data[2:0];
                gcpb_pkg::REG_GREEN_UP:   fmt_reg.green_up   <= cfg_data[3:0];
                gcpb_pkg::REG_BLUE_DOWN:  fmt_reg.blue_down  <= cfg_data[2:0];
                default:
                begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    // The input register moves on whenever the result register is empty or
    // is being emptied this cycle; it takes a new request whenever it is
    // empty or moving on.
    assign s1_advance = !out_valid_reg || out_ready;
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;

    always_comb
    begin
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_advance)
        begin
            out_valid_next = s1_valid_reg;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cov_reg  <= coverage;
            dest_reg <= dest_pixel;
        end
        if (s1_advance && s1_valid_reg)
        begin
            new_pixel_reg    <= new_pixel_next;
            write_enable_reg <= write_enable_next;
        end
    end

    // Text color split into its channels and packed into the pixel format.
    assign col_r        = text_color_reg[7:0];
    assign col_g        = text_color_reg[15:8];
    assign col_b        = text_color_reg[23:16];
    assign packed_color = gcpb_pkg::pack_px(col_r, col_g, col_b, fmt_reg);

    // Destination channels; blue always sits at bit zero.
    assign dst_r = gcpb_pkg::unpack_ch(dest_reg, fmt_reg.red_up, fmt_reg.red_down);
    assign dst_g = gcpb_pkg::unpack_ch(dest_reg, fmt_reg.green_up, fmt_reg.green_down);
    assign dst_b = gcpb_pkg::unpack_ch(dest_reg, '0, fmt_reg.blue_down);

    // Coverage-weighted mix of each channel, repacked.
    assign blended = gcpb_pkg::pack_px(gcpb_pkg::mix_ch(dst_r, col_r, cov_reg),
                                       gcpb_pkg::mix_ch(dst_g, col_g, cov_reg),
                                       gcpb_pkg::mix_ch(dst_b, col_b, cov_reg),
                                       fmt_reg);

    // Empty coverage leaves the pixel alone. Solid mode and full coverage
    // write the packed color; partial coverage in blend mode writes the mix.
    always_comb
    begin
        if (cov_reg == gcpb_pkg::COV_NONE)
        begin
            new_pixel_next    = dest_reg;
            write_enable_next = 1'b0;
        end
        else if (blend_mode_reg == gcpb_pkg::MODE_SOLID ||
                 cov_reg == gcpb_pkg::COV_FULL)
        begin
            new_pixel_next    = packed_color;
            write_enable_next = 1'b1;
        end
        else
        begin
            new_pixel_next    = blended;
            write_enable_next = 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign new_pixel    = new_pixel_reg;
    assign write_enable = write_enable_reg;

endmodule

/* sv/gcpb_checker.sv */
// ----------------------------------------------------------------------------
// Glyph coverage pixel blend checker
// Port-level assertions on the compositor, bound to the top level.
// ----------------------------------------------------------------------------
`include "glyph_coverage_pixel_blend_top_macros.svh"

module gcpb_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic [gcpb_pkg::COV_W-1:0]       coverage,
    input logic [gcpb_pkg::PIXEL_W-1:0]     dest_pixel,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [gcpb_pkg::PIXEL_W-1:0]     new_pixel,
    input logic                             write_enable
);

    // A stalled result holds still.
    `GCPB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(new_pixel) && $stable(write_enable), "result changed while stalled")

    // With no stall in the way, an accepted request shows up as a result and its
    // write enable follows the coverage byte.
    `GCPB_ASSERT_NEXT(a_we_follows_cov, (in_valid && in_ready) ##1 out_ready, out_valid && (write_enable == ($past(coverage, 2) != gcpb_pkg::COV_NONE)), "write enable does not follow coverage")

    // Empty coverage passes the destination pixel through untouched.
    `GCPB_ASSERT_NEXT(a_empty_passthru, (in_valid && in_ready && coverage == gcpb_pkg::COV_NONE) ##1 out_ready, out_valid && new_pixel == $past(dest_pixel, 2), "empty coverage altered the pixel")

endmodule

bind glyph_coverage_pixel_blend_top gcpb_checker u_gcpb_checker (.*);

/* test/gcpb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph coverage pixel blend scoreboard
// Watches the register, request and result channels, keeps its own copy of
// the configuration, predicts each pixel and compares it with the block.
// ----------------------------------------------------------------------------
module gcpb_scoreboard (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  gcpb_pkg::cfg_index_t            cfg_index,
    input  logic [gcpb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  gcpb_pkg::cov_t                  coverage,
    input  gcpb_pkg::pixel_t                dest_pixel,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  gcpb_pkg::pixel_t                new_pixel,
    input  logic                            write_enable,
    output int                              mismatch_count,
    output int                              results_pending
);

    typedef struct packed {
        gcpb_pkg::pixel_t px;
        logic             we;
    } pixel_write_t;

    // Shadow of the block's registers.
    logic [gcpb_pkg::COLOR_W-1:0] shadow_color;
    logic                         shadow_mode;
    gcpb_pkg::fmt_t               shadow_fmt;

    pixel_write_t                 pending_writes[$];

    // Squeeze three 8-bit channels into the configured 16-bit layout.
    function automatic gcpb_pkg::pixel_t fold_channels(gcpb_pkg::chan_t r,
                                                       gcpb_pkg::chan_t g,
                                                       gcpb_pkg::chan_t b);
        int unsigned rw;
        int unsigned gw;
        int unsigned bw;
        rw = r;
        gw = g;
        bw = b;
        rw = (rw >> shadow_fmt.red_down) << shadow_fmt.red_up;
        gw = (gw >> shadow_fmt.green_down) << shadow_fmt.green_up;
        bw = bw >> shadow_fmt.blue_down;
        return gcpb_pkg::pixel_t'((rw | gw | bw) & 'hffff);
    endfunction

    // Recover an 8-bit channel from its field; bits shifted past bit 7 are lost.
    function automatic gcpb_pkg::chan_t extract_channel(gcpb_pkg::pixel_t px,
                                                        int unsigned up,
                                                        int unsigned down);
        int unsigned w;
        w = px;
        w = (w >> up) & 'hff;
        w = (w << down) & 'hff;
        return gcpb_pkg::chan_t'(w);
    endfunction

    function automatic gcpb_pkg::chan_t mix_channel(gcpb_pkg::chan_t d,
                                                    gcpb_pkg::chan_t col,
                                                    gcpb_pkg::cov_t c);
        int unsigned dw;
        int unsigned colw;
        int unsigned cw;
        dw   = d;
        colw = col;
        cw   = c;
        return gcpb_pkg::chan_t'(((dw * (255 - cw)) / 256 + (colw * cw) / 256) & 'hff);
    endfunction

    function automatic pixel_write_t composite_pixel(gcpb_pkg::cov_t c,
                                                     gcpb_pkg::pixel_t dp);
        pixel_write_t    res;
        gcpb_pkg::chan_t red;
        gcpb_pkg::chan_t green;
        gcpb_pkg::chan_t blue;
        red    = shadow_color[7:0];
        green  = shadow_color[15:8];
        blue   = shadow_color[23:16];
        res.px = dp;
        res.we = 1'b0;
        if (c != gcpb_pkg::COV_NONE) begin
            res.we = 1'b1;
            if (shadow_mode == gcpb_pkg::MODE_SOLID || c == gcpb_pkg::COV_FULL) begin
                res.px = fold_channels(red, green, blue);
            end
            else begin
                res.px = fold_channels(
                    mix_channel(extract_channel(dp, shadow_fmt.red_up,
                                                shadow_fmt.red_down), red, c),
                    mix_channel(extract_channel(dp, shadow_fmt.green_up,
                                                shadow_fmt.green_down), green, c),
                    mix_channel(extract_channel(dp, 0, shadow_fmt.blue_down),
                                blue, c));
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_write_t want;
        if (!rst_n) begin
            shadow_color    = gcpb_pkg::RST_TEXT_COLOR;
            shadow_mode     = gcpb_pkg::RST_BLEND_MODE;
            shadow_fmt      = gcpb_pkg::RST_FMT;
            mismatch_count  = 0;
            results_pending = 0;
            pending_writes.delete();
        end
        else begin
            // A result can never belong to a request taken on the same edge,
            // so results are retired before new requests are predicted.
            if (out_valid && out_ready) begin
                if (pending_writes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with nothing outstanding: px=%h we=%b",
                                 $realtime, new_pixel, write_enable);
                end
                else begin
                    want = pending_writes.pop_front();
                    if (new_pixel !== want.px || write_enable !== want.we) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: mismatch: px exp %h got %h, we exp %b got %b",
                                     $realtime, want.px, new_pixel, want.we,
                                     write_enable);
                    end
                end
            end
            if (in_valid && in_ready)
                pending_writes.push_back(composite_pixel(coverage, dest_pixel));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    gcpb_pkg::REG_TEXT_COLOR:
                        shadow_color = cfg_data;
                    gcpb_pkg::REG_BLEND_MODE:
                        shadow_mode = cfg_data[0];
                    gcpb_pkg::REG_RED_DOWN:
                        shadow_fmt.red_down = cfg_data[gcpb_pkg::DOWN_W-1:0];
                    gcpb_pkg::REG_RED_UP:
                        shadow_fmt.red_up = cfg_data[gcpb_pkg::UP_W-1:0];
                    gcpb_pkg::REG_GREEN_DOWN:
                        shadow_fmt.green_down = cfg_data[gcpb_pkg::DOWN_W-1:0];
                    gcpb_pkg::REG_GREEN_UP:
                        shadow_fmt.green_up = cfg_data[gcpb_pkg::UP_W-1:0];
                    gcpb_pkg::REG_BLUE_DOWN:
                        shadow_fmt.blue_down = cfg_data[gcpb_pkg::DOWN_W-1:0];
                    default: ;
                endcase
            end
            results_pending = pending_writes.size();
        end
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph coverage pixel blend testbench
// Drives register writes and pixel requests into the compositor with random
// gaps and output stalls; the scoreboard beside the block predicts every pixel.
// ----------------------------------------------------------------------------
module tb_top;

    // The block answers a request through its input and result registers; allow
    // settling time before touching registers or giving the verdict.
    localparam int DRAIN_CYCLES = 6;
    // Worst case is far below this: about 1100 requests, each meeting the
    // longest sender gap and result stall that the bench draws.
    localparam int CYCLE_LIMIT  = 200000;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    gcpb_pkg::cfg_index_t            cfg_index;
    logic [gcpb_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    gcpb_pkg::cov_t                  coverage;
    gcpb_pkg::pixel_t                dest_pixel;
    logic                            out_valid;
    logic                            out_ready;
    gcpb_pkg::pixel_t                new_pixel;
    logic                            write_enable;

    int                              mismatch_count;
    int                              results_pending;
    int                              cycle_count;

    // Idling switches; the stimulus turns them on and off per phase.
    bit                              gaps_on;
    bit                              stalls_on;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    glyph_coverage_pixel_blend_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .coverage     (coverage),
        .dest_pixel   (dest_pixel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .new_pixel    (new_pixel),
        .write_enable (write_enable)
    );

    gcpb_scoreboard u_scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .coverage        (coverage),
        .dest_pixel      (dest_pixel),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .new_pixel       (new_pixel),
        .write_enable    (write_enable),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // Present one register write and hold it until it is taken. The valid
    // stays high on return so that back-to-back writes never drop it; the
    // caller lowers it after the last write.
    task automatic put_reg(gcpb_pkg::cfg_index_t idx,
                           logic [gcpb_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic program_regs(logic [gcpb_pkg::COLOR_W-1:0] color, logic mode,
                                gcpb_pkg::fmt_t f);
        put_reg(gcpb_pkg::REG_TEXT_COLOR, color);
        put_reg(gcpb_pkg::REG_BLEND_MODE, gcpb_pkg::CFG_DATA_W'(mode));
        put_reg(gcpb_pkg::REG_RED_DOWN,   gcpb_pkg::CFG_DATA_W'(f.red_down));
        put_reg(gcpb_pkg::REG_RED_UP,     gcpb_pkg::CFG_DATA_W'(f.red_up));
        put_reg(gcpb_pkg::REG_GREEN_DOWN, gcpb_pkg::CFG_DATA_W'(f.green_down));
        put_reg(gcpb_pkg::REG_GREEN_UP,   gcpb_pkg::CFG_DATA_W'(f.green_up));
        put_reg(gcpb_pkg::REG_BLUE_DOWN,  gcpb_pkg::CFG_DATA_W'(f.blue_down));
        cfg_valid <= 1'b0;
    endtask

    // Send one pixel request. A gap, when taken, lowers the valid for a
    // burst of cycles first; otherwise the valid stays high from the
    // previous request so the block sees back-to-back traffic.
    task automatic send_pixel(gcpb_pkg::cov_t c, gcpb_pkg::pixel_t p);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        coverage   <= c;
        dest_pixel <= p;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Called at a falling edge with the request valid already low. Waits
    // until every predicted pixel has come back, then lets the pipeline
    // settle before registers are touched again.
    task automatic wait_drained();
        while (results_pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Coverage leans on the special values: empty, full, and the ones just
    // inside them, where the blend arithmetic is most likely to be off.
    function automatic gcpb_pkg::cov_t pick_coverage();
        case ($urandom_range(0, 7))
            0:       return gcpb_pkg::COV_NONE;
            1:       return gcpb_pkg::COV_FULL;
            2:       return gcpb_pkg::cov_t'(1);
            3:       return gcpb_pkg::COV_FULL - gcpb_pkg::cov_t'(1);
            default: return gcpb_pkg::cov_t'($urandom_range(0, 255));
        endcase
    endfunction

    // Arbitrary layouts half the time; the reset layout and both extremes of
    // the shift ranges make up the rest.
    function automatic gcpb_pkg::fmt_t pick_format();
        gcpb_pkg::fmt_t f;
        case ($urandom_range(0, 7))
            0, 1: f = gcpb_pkg::RST_FMT;
            2:    f = '0;
            3:    f = '1;
            default:
            begin
                f.red_down   = gcpb_pkg::DOWN_W'($urandom_range(0, 7));
                f.red_up     = gcpb_pkg::UP_W'($urandom_range(0, 15));
                f.green_down = gcpb_pkg::DOWN_W'($urandom_range(0, 7));
                f.green_up   = gcpb_pkg::UP_W'($urandom_range(0, 15));
                f.blue_down  = gcpb_pkg::DOWN_W'($urandom_range(0, 7));
            end
        endcase
        return f;
    endfunction

    function automatic logic [gcpb_pkg::COLOR_W-1:0] pick_color();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return gcpb_pkg::COLOR_W'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    // Result side: random stall bursts while enabled, otherwise always ready.
    initial
    begin
        out_ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (stalls_on && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        gcpb_pkg::fmt_t f;
        gcpb_pkg::fmt_t fmt_zero;
        gcpb_pkg::fmt_t fmt_ones;
        fmt_zero   = '0;
        fmt_ones   = '1;
        gaps_on    = 1'b0;
        stalls_on  = 1'b0;
        rst_n      <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= gcpb_pkg::REG_TEXT_COLOR;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        coverage   <= gcpb_pkg::COV_NONE;
        dest_pixel <= '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: solid white in the 5-6-5 layout.
        send_pixel(gcpb_pkg::COV_NONE, 16'h1234);
        send_pixel(gcpb_pkg::cov_t'(1), 16'h0000);
        send_pixel(gcpb_pkg::COV_FULL, 16'hFFFF);
        in_valid <= 1'b0;
        wait_drained();

        // Blend in the reset layout with pure green text: empty and full
        // coverage, the values next to them and the middle, over extreme
        // and alternating destination patterns.
        program_regs(24'h00FF00, gcpb_pkg::MODE_BLEND, gcpb_pkg::RST_FMT);
        send_pixel(gcpb_pkg::COV_NONE, 16'hFFFF);
        send_pixel(gcpb_pkg::cov_t'(1), 16'hFFFF);
        send_pixel(gcpb_pkg::cov_t'(128), 16'h0000);
        send_pixel(gcpb_pkg::cov_t'(128), 16'hFFFF);
        send_pixel(gcpb_pkg::COV_FULL - gcpb_pkg::cov_t'(1), 16'hAAAA);
        send_pixel(gcpb_pkg::COV_FULL, 16'h5555);
        send_pixel(gcpb_pkg::cov_t'(127), 16'h5555);
        in_valid <= 1'b0;
        wait_drained();

        // Every shift at zero: all three channels land on the same bits.
        program_regs(24'hA5C3E1, gcpb_pkg::MODE_BLEND, fmt_zero);
        send_pixel(gcpb_pkg::cov_t'(1), 16'hFFFF);
        send_pixel(gcpb_pkg::cov_t'(200), 16'h0F0F);
        send_pixel(gcpb_pkg::COV_FULL, 16'h0000);
        in_valid <= 1'b0;
        wait_drained();

        // Every shift at its maximum: fields run off the top of the pixel.
        program_regs(24'h000000, gcpb_pkg::MODE_BLEND, fmt_ones);
        send_pixel(gcpb_pkg::cov_t'(77), 16'hFFFF);
        send_pixel(gcpb_pkg::COV_FULL - gcpb_pkg::cov_t'(1), 16'h8001);
        in_valid <= 1'b0;
        wait_drained();

        program_regs(24'hFFFFFF, gcpb_pkg::MODE_SOLID, fmt_ones);
        send_pixel(gcpb_pkg::cov_t'(2), 16'h0000);
        send_pixel(gcpb_pkg::COV_NONE, 16'hBEEF);
        in_valid <= 1'b0;
        wait_drained();

        // Random phases. Each one starts from an idle block, so the sender
        // always pauses here until every pixel has come back. Blend mode is
        // favored since solid mode exercises little of the datapath. The
        // last phase runs with no idling at all.
        for (int phase = 0; phase < 10; phase++) begin
            f = pick_format();
            program_regs(pick_color(),
                         ($urandom_range(0, 3) != 0) ? gcpb_pkg::MODE_BLEND
                                                     : gcpb_pkg::MODE_SOLID, f);
            gaps_on   = (phase < 9) && ($urandom_range(0, 3) != 0);
            stalls_on = (phase < 9) && ($urandom_range(0, 3) != 0);
            repeat ((phase < 9) ? 100 : 150)
                send_pixel(pick_coverage(),
                           gcpb_pkg::pixel_t'($urandom_range(0, 16'hFFFF)));
            in_valid <= 1'b0;
            wait_drained();
        end

        if (mismatch_count == 0 && results_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
